### src/npfp_pkg.sv
// shared types, constants and helpers of the position sentence parser
`default_nettype none

package npfp_pkg;

  // field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned LatW     = 27;
  localparam int unsigned LonW     = 28;
  localparam int unsigned CommaW   = 3;
  localparam int unsigned FracCntW = 3;

  // default count of kept fraction digits
  localparam int unsigned FractionDigitsDefault = 4;

  // saturation limits of the scaled coordinates
  localparam logic [LatW-1:0] LatLimit = LatW'(90000000);
  localparam logic [LonW-1:0] LonLimit = LonW'(180000000);

  // characters of interest
  localparam logic [CharW-1:0] CommaChar = 8'h2C;  // ','
  localparam logic [CharW-1:0] PointChar = 8'h2E;  // '.'
  localparam logic [CharW-1:0] FixChar   = 8'h41;  // 'A'
  localparam logic [CharW-1:0] NoFixChar = 8'h56;  // 'V'
  localparam logic [CharW-1:0] DigitLo   = 8'h30;  // '0'
  localparam logic [CharW-1:0] DigitHi   = 8'h39;  // '9'

  // comma counts that open the fields of interest
  localparam logic [CommaW-1:0] StatusField = 3'd2;
  localparam logic [CommaW-1:0] LatField    = 3'd3;
  localparam logic [CommaW-1:0] LonField    = 3'd5;
  localparam logic [CommaW-1:0] CommaMax    = 3'd7;

  // input transaction
  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             end_of_sentence;
    logic             force_report;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [LatW-1:0] latitude_scaled;
    logic [LonW-1:0] longitude_scaled;
    logic            fix_valid;
    logic            format_error;
  } out_t;

  // power of ten for the fraction padding
  function automatic logic [31:0] pow10(input logic [FracCntW-1:0] n);
    logic [31:0] p;
    unique case (n)
      3'd0:    p = 32'd1;
      3'd1:    p = 32'd10;
      3'd2:    p = 32'd100;
      3'd3:    p = 32'd1000;
      3'd4:    p = 32'd10000;
      3'd5:    p = 32'd100000;
      3'd6:    p = 32'd1000000;
      default: p = 32'd10000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### src/nmea_position_field_parser.sv
// position sentence parser: byte stream in, scaled coordinates out
//
//  channel | direction | payload           | handshake
//  --------+-----------+-------------------+------------------------
//  in      | input     | npfp_pkg::in_t    | in_valid_i / in_ready_o
//  out     | output    | npfp_pkg::out_t   | out_valid_o / out_ready_i
//
// one character per cycle while no final character stalls; a character is
// registered, then parsed, and a final character's result is registered.
// the shared multiply-by-ten and padding multiplier set the per-cycle path.
// reset clears the sentence state and both valid flags.
// a full result register stalls only a final character; other characters
// keep flowing while a result waits to be taken.
`default_nettype none

module nmea_position_field_parser #(
  parameter int unsigned FractionDigits = npfp_pkg::FractionDigitsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire npfp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output npfp_pkg::out_t      out_data_o
);

  localparam int unsigned PowW  = $clog2(10 ** FractionDigits + 1);
  localparam int unsigned ProdW = npfp_pkg::LonW + PowW;
  localparam int unsigned StepW = npfp_pkg::LonW + 4;
  localparam logic [npfp_pkg::FracCntW-1:0] FracMax = npfp_pkg::FracCntW'(FractionDigits);

  // input register
  logic          in_vld_q;
  npfp_pkg::in_t in_item_q;

  // sentence state
  logic [npfp_pkg::CommaW-1:0]   comma_q, comma_d;
  logic [npfp_pkg::LatW-1:0]     lat_q, lat_d;
  logic [npfp_pkg::LonW-1:0]     lon_q, lon_d;
  logic [npfp_pkg::FracCntW-1:0] frac_q, frac_d;
  logic                          after_q, after_d;
  logic                          stopped_q, stopped_d;
  logic                          status_q, status_d;

  // result register
  logic           out_vld_q;
  npfp_pkg::out_t out_q, out_d;

  logic advance;
  logic [npfp_pkg::CharW-1:0] c;
  logic is_digit, is_comma, is_point, in_lat, in_lon;
  logic [npfp_pkg::LonW-1:0] acc_cur, limit_cur, step_sat, fin_sat, acc_new;
  logic [StepW-1:0] step_wide;
  logic [npfp_pkg::FracCntW-1:0] pad;
  logic [31:0] pow_full;
  logic [PowW-1:0] pow_val;
  logic [ProdW-1:0] prod;
  logic complete, report;

  // the staged character moves on unless it is final and the result slot is full and not being taken
  assign advance = in_vld_q &&
                   (!in_item_q.end_of_sentence || !out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // character classes
  assign c        = in_item_q.char_byte;
  assign is_digit = (c >= npfp_pkg::DigitLo) && (c <= npfp_pkg::DigitHi);
  assign is_comma = (c == npfp_pkg::CommaChar);
  assign is_point = (c == npfp_pkg::PointChar);
  assign in_lat   = (comma_q == npfp_pkg::LatField);
  assign in_lon   = (comma_q == npfp_pkg::LonField);

  // shared accumulator path for whichever coordinate field is open
  assign acc_cur   = in_lat ? {1'b0, lat_q} : lon_q;
  assign limit_cur = in_lat ? {1'b0, npfp_pkg::LatLimit} : npfp_pkg::LonLimit;

  // multiply by ten and add the digit
  assign step_wide = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1)
                   + {{(StepW-4){1'b0}}, c[3:0]};
  assign step_sat  = (step_wide > {4'b0, limit_cur}) ? limit_cur
                                                     : step_wide[npfp_pkg::LonW-1:0];

  // pad the missing fraction digits when the field closes
  assign pad      = FracMax - frac_q;
  assign pow_full = npfp_pkg::pow10(pad);
  assign pow_val  = pow_full[PowW-1:0];
  assign prod     = {{PowW{1'b0}}, acc_cur} * {{npfp_pkg::LonW{1'b0}}, pow_val};
  assign fin_sat  = (prod > {{PowW{1'b0}}, limit_cur}) ? limit_cur
                                                       : prod[npfp_pkg::LonW-1:0];

  // parse one character and build the result on the final one
  always_comb begin
    comma_d   = comma_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    frac_d    = frac_q;
    after_d   = after_q;
    stopped_d = stopped_q;
    status_d  = status_q;
    acc_new   = acc_cur;
    out_d     = out_q;
    complete  = 1'b0;
    report    = 1'b0;
    if (advance) begin
      if (is_comma) begin
        if (in_lat) begin
          lat_d = fin_sat[npfp_pkg::LatW-1:0];
        end else if (in_lon) begin
          lon_d = fin_sat;
        end
        if (comma_q != npfp_pkg::CommaMax) begin
          comma_d = comma_q + 1'b1;
        end
        frac_d    = '0;
        after_d   = 1'b0;
        stopped_d = 1'b0;
      end else if (comma_q == npfp_pkg::StatusField) begin
        // only the first character of the status field counts
        if (!stopped_q) begin
          status_d  = (c == npfp_pkg::FixChar);
          stopped_d = 1'b1;
        end
      end else if (in_lat || in_lon) begin
        if (!stopped_q) begin
          if (is_digit) begin
            if (!(after_q && (frac_q >= FracMax))) begin
              if (after_q) begin
                frac_d = frac_q + 1'b1;
              end
              acc_new = step_sat;
            end
          end else if (is_point && !after_q) begin
            after_d = 1'b1;
          end else begin
            stopped_d = 1'b1;
          end
        end
        if (in_lat) begin
          lat_d = acc_new[npfp_pkg::LatW-1:0];
        end else begin
          lon_d = acc_new;
        end
      end

      if (in_item_q.end_of_sentence) begin
        complete = (comma_d == npfp_pkg::CommaMax);
        report   = complete && (status_d || in_item_q.force_report);
        out_d.latitude_scaled  = report ? lat_d : '0;
        out_d.longitude_scaled = report ? lon_d : '0;
        out_d.fix_valid        = status_d;
        out_d.format_error     = !complete;
        // fresh state for the next sentence
        comma_d   = '0;
        lat_d     = '0;
        lon_d     = '0;
        frac_d    = '0;
        after_d   = 1'b0;
        stopped_d = 1'b0;
        status_d  = 1'b0;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      comma_q   <= '0;
      lat_q     <= '0;
      lon_q     <= '0;
      frac_q    <= '0;
      after_q   <= 1'b0;
      stopped_q <= 1'b0;
      status_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance && in_item_q.end_of_sentence) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      comma_q   <= comma_d;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
      frac_q    <= frac_d;
      after_q   <= after_d;
      stopped_q <= stopped_d;
      status_q  <= status_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    out_q <= out_d;
  end

endmodule

`default_nettype wire

### src/npfp_checker.sv
// port-level checks of the position sentence parser, bound to the top level
`default_nettype none

module npfp_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire npfp_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire npfp_pkg::out_t out_data_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a format error never carries coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.format_error |->
      out_data_o.latitude_scaled == '0 && out_data_o.longitude_scaled == '0)
    else $error("coordinates reported with format error");

  // coordinates stay within their saturation limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.latitude_scaled <= npfp_pkg::LatLimit &&
                    out_data_o.longitude_scaled <= npfp_pkg::LonLimit)
    else $error("coordinate above limit");

  // a fresh result follows an accepted final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && in_data_i.end_of_sentence, 2))
    else $error("result without final character");

endmodule

bind nmea_position_field_parser npfp_checker u_npfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
